// ===== src/bcs_pkg.sv =====
package bcs_pkg;

  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned POS_W       = OFFSET_BITS + 1;
  localparam int unsigned OFF_FIELD_W = 16;

  localparam logic [POS_W-1:0] OFFSET_MAX = POS_W'((64'd1 << OFFSET_BITS) - 64'd1);
  localparam logic [POS_W-1:0] POS_CAP    = POS_W'((64'd1 << OFFSET_BITS) + 64'd1);

  typedef enum logic [0:0] {
    CFG_MODE    = 1'b0,
    CFG_PATTERN = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    MODE_ONE         = 4'd0,
    MODE_SET2        = 4'd1,
    MODE_SET3        = 4'd2,
    MODE_SET4        = 4'd3,
    MODE_SET5        = 4'd4,
    MODE_SET6        = 4'd5,
    MODE_SET7        = 4'd6,
    MODE_SET8        = 4'd7,
    MODE_PAIR        = 4'd8,
    MODE_PAIR_SET2   = 4'd9,
    MODE_PAIR_SET3   = 4'd10,
    MODE_PAIR_SET4   = 4'd11,
    MODE_RANGE       = 4'd12,
    MODE_RANGE_PAIR  = 4'd13,
    MODE_TRIPLET     = 4'd14,
    MODE_TRIPLET_SET = 4'd15
  } mode_e;

  typedef enum logic [1:0] {
    LEN_ONE   = 2'd1,
    LEN_TWO   = 2'd2,
    LEN_THREE = 2'd3
  } seq_len_e;

  typedef struct packed {
    logic     c1;
    logic     c2;
    logic     c3;
    seq_len_e len;
  } cls_t;

  typedef struct packed {
    logic adv;
    logic first;
    logic last;
  } step_t;

  typedef struct packed {
    logic                   emit;
    logic                   found;
    logic [OFF_FIELD_W-1:0] offset;
  } res_t;

  function automatic logic [7:0] pat(input logic [63:0] p, input logic [2:0] idx);
    return p[idx*8 +: 8];
  endfunction

  function automatic logic in_set(input logic [7:0] x, input logic [63:0] p,
                                  input logic [2:0] start, input logic [3:0] count);
    logic r;
    r = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) < count) && (x == pat(p, 3'(start + 3'(i))))) r = 1'b1;
    end
    return r;
  endfunction

  function automatic logic in_range(input logic [7:0] x, input logic [63:0] p,
                                    input logic [2:0] lo_idx);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = pat(p, lo_idx);
    hi = pat(p, 3'(lo_idx + 3'd1));
    return (8'(x - lo) <= 8'(hi - lo));
  endfunction

endpackage

// ===== src/bcs_byte_if.sv =====
interface bcs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_buffer;
  logic       last_of_buffer;

  modport source (output valid, output data_byte, output first_of_buffer,
                  output last_of_buffer, input ready);
  modport sink (input valid, input data_byte, input first_of_buffer,
                input last_of_buffer, output ready);
endinterface

// ===== src/bcs_result_if.sv =====
interface bcs_result_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic [bcs_pkg::OFF_FIELD_W-1:0]    match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink (input valid, input found, input match_offset, output ready);
endinterface

// ===== src/bcs_classify.sv =====
module bcs_classify (
  input  logic [3:0]    mode_i,
  input  logic [63:0]   pattern_i,
  input  logic [7:0]    byte_i,
  output bcs_pkg::cls_t cls_o
);

  logic [3:0] k;

  assign k = 4'(mode_i - 4'd7);

  always_comb begin
    cls_o = '{c1: 1'b0, c2: 1'b0, c3: 1'b0, len: bcs_pkg::LEN_ONE};
    unique case (bcs_pkg::mode_e'(mode_i)) inside
      bcs_pkg::MODE_ONE, bcs_pkg::MODE_SET2, bcs_pkg::MODE_SET3, bcs_pkg::MODE_SET4,
      bcs_pkg::MODE_SET5, bcs_pkg::MODE_SET6, bcs_pkg::MODE_SET7,
      bcs_pkg::MODE_SET8: begin
        cls_o.c1 = bcs_pkg::in_set(byte_i, pattern_i, 3'd0, 4'(mode_i + 4'd1));
      end
      bcs_pkg::MODE_PAIR: begin
        cls_o.c1  = bcs_pkg::in_set(byte_i, pattern_i, 3'd0, 4'd1);
        cls_o.c2  = bcs_pkg::in_set(byte_i, pattern_i, 3'd1, 4'd1);
        cls_o.len = bcs_pkg::LEN_TWO;
      end
      bcs_pkg::MODE_PAIR_SET2, bcs_pkg::MODE_PAIR_SET3, bcs_pkg::MODE_PAIR_SET4: begin
        cls_o.c1  = bcs_pkg::in_set(byte_i, pattern_i, 3'd0, k);
        cls_o.c2  = bcs_pkg::in_set(byte_i, pattern_i, k[2:0], k);
        cls_o.len = bcs_pkg::LEN_TWO;
      end
      bcs_pkg::MODE_RANGE: begin
        cls_o.c1 = bcs_pkg::in_range(byte_i, pattern_i, 3'd0);
      end
      bcs_pkg::MODE_RANGE_PAIR: begin
        cls_o.c1  = bcs_pkg::in_range(byte_i, pattern_i, 3'd0);
        cls_o.c2  = bcs_pkg::in_range(byte_i, pattern_i, 3'd2);
        cls_o.len = bcs_pkg::LEN_TWO;
      end
      bcs_pkg::MODE_TRIPLET: begin
        cls_o.c1  = bcs_pkg::in_set(byte_i, pattern_i, 3'd0, 4'd1);
        cls_o.c2  = bcs_pkg::in_set(byte_i, pattern_i, 3'd1, 4'd1);
        cls_o.c3  = bcs_pkg::in_set(byte_i, pattern_i, 3'd2, 4'd1);
        cls_o.len = bcs_pkg::LEN_THREE;
      end
      bcs_pkg::MODE_TRIPLET_SET: begin
        cls_o.c1  = bcs_pkg::in_set(byte_i, pattern_i, 3'd0, 4'd2);
        cls_o.c2  = bcs_pkg::in_set(byte_i, pattern_i, 3'd2, 4'd2);
        cls_o.c3  = bcs_pkg::in_set(byte_i, pattern_i, 3'd4, 4'd2);
        cls_o.len = bcs_pkg::LEN_THREE;
      end
      default: begin
        cls_o = '{c1: 1'b0, c2: 1'b0, c3: 1'b0, len: bcs_pkg::LEN_ONE};
      end
    endcase
  end

endmodule

// ===== src/bcs_cell.sv =====
module bcs_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bcs_pkg::step_t step_i,
  input  logic           link_i,
  input  logic           class_i,
  output logic           hit_o,
  output logic           link_o
);

  logic hit_q, hit_d;

  assign hit_o = link_i & class_i;

  always_comb begin
    hit_d = hit_q;
    if (step_i.adv) hit_d = step_i.last ? 1'b0 : hit_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign link_o = hit_q;

endmodule

// ===== src/bcs_track.sv =====
module bcs_track (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcs_pkg::step_t    step_i,
  input  bcs_pkg::seq_len_e len_i,
  input  logic [2:0]        hits_i,
  output bcs_pkg::res_t     res_o
);

  logic [bcs_pkg::POS_W-1:0]                  pos_q, pos_d;
  logic                                       answered_q, answered_d;
  logic [bcs_pkg::POS_W-1:0]                  cur;
  logic [bcs_pkg::POS_W-1:0]                  back;
  logic [bcs_pkg::POS_W-1:0]                  off;
  logic [bcs_pkg::POS_W+bcs_pkg::OFF_FIELD_W-1:0] off_ext;
  logic                                       answered_eff;
  logic                                       hit;

  assign cur          = step_i.first ? '0 : pos_q;
  assign answered_eff = answered_q & ~step_i.first;
  assign back         = bcs_pkg::POS_W'(len_i) - bcs_pkg::POS_W'(1);

  always_comb begin
    case (len_i)
      bcs_pkg::LEN_TWO:   hit = hits_i[1];
      bcs_pkg::LEN_THREE: hit = hits_i[2];
      default:            hit = hits_i[0];
    endcase
  end

  always_comb begin
    off = (cur >= back) ? cur - back : '0;
    if (off > bcs_pkg::OFFSET_MAX) off = bcs_pkg::OFFSET_MAX;
  end

  assign off_ext = {{bcs_pkg::OFF_FIELD_W{1'b0}}, off};

  always_comb begin
    res_o.emit   = step_i.adv & ~answered_eff & (hit | step_i.last);
    res_o.found  = hit;
    res_o.offset = hit ? off_ext[bcs_pkg::OFF_FIELD_W-1:0] : '0;
  end

  always_comb begin
    pos_d      = pos_q;
    answered_d = answered_q;
    if (step_i.adv) begin
      if (step_i.last) begin
        pos_d      = '0;
        answered_d = 1'b0;
      end else begin
        pos_d      = (cur < bcs_pkg::POS_CAP) ? cur + bcs_pkg::POS_W'(1) : cur;
        answered_d = answered_eff | hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      answered_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      answered_q <= answered_d;
    end
  end

endmodule

// ===== src/byte_class_sequence_scanner_core.sv =====
// Output: a result is registered and appears on the output in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the match history moves one cell along the
// chain per accepted byte and the output register holds one result, so the
// input stalls only while a held result is not taken.
// Reset: mode, pattern bytes, history cells, position and output valid all clear.
module byte_class_sequence_scanner_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  bcs_byte_if.sink            in_ch,
  bcs_result_if.source        out_ch
);

  logic [3:0]                      mode_q;
  logic [63:0]                     pattern_q;
  logic                            out_valid_q, out_valid_d;
  logic                            found_q;
  logic [bcs_pkg::OFF_FIELD_W-1:0] offset_q;
  bcs_pkg::cls_t                   cls;
  bcs_pkg::step_t                  step;
  bcs_pkg::res_t                   res;
  logic                            hit0, hit1;
  logic                            link0, link1;
  logic                            hit2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      pattern_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bcs_pkg::cfg_idx_e'(cfg_index_i))
        bcs_pkg::CFG_MODE:    mode_q    <= cfg_data_i[3:0];
        bcs_pkg::CFG_PATTERN: pattern_q <= cfg_data_i;
        default:              mode_q    <= mode_q;
      endcase
    end
  end

  assign in_ch.ready = ~out_valid_q | out_ch.ready;
  assign step.adv    = in_ch.valid & in_ch.ready;
  assign step.first  = in_ch.first_of_buffer;
  assign step.last   = in_ch.last_of_buffer;

  bcs_classify u_classify (
    .mode_i    (mode_q),
    .pattern_i (pattern_q),
    .byte_i    (in_ch.data_byte),
    .cls_o     (cls)
  );

  bcs_cell u_cell0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .link_i  (1'b1),
    .class_i (cls.c1),
    .hit_o   (hit0),
    .link_o  (link0)
  );

  bcs_cell u_cell1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .link_i  (link0 & ~step.first),
    .class_i (cls.c2),
    .hit_o   (hit1),
    .link_o  (link1)
  );

  assign hit2 = link1 & ~step.first & cls.c3;

  bcs_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .len_i  (cls.len),
    .hits_i ({hit2, hit1, hit0}),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.emit)          out_valid_d = 1'b1;
    else if (out_ch.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.emit) begin
      found_q  <= res.found;
      offset_q <= res.offset;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.found        = found_q;
  assign out_ch.match_offset = offset_q;

endmodule

// ===== src/bcs_checker.sv =====
module bcs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_first,
  input logic                            in_last,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_found,
  input logic [bcs_pkg::OFF_FIELD_W-1:0] out_offset
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result transfer dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_found) && $stable(out_offset))
    else $error("result payload changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_found |-> out_offset == '0)
    else $error("miss result with non-zero offset");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

  a_single_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_first && in_last |=> out_valid)
    else $error("single-byte buffer gave no result");

endmodule

bind byte_class_sequence_scanner_core bcs_checker u_bcs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_first   (in_ch.first_of_buffer),
  .in_last    (in_ch.last_of_buffer),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_found  (out_ch.found),
  .out_offset (out_ch.match_offset)
);

// ===== sim/bcs_scan_checker.sv =====
`timescale 1ns / 1ps

module bcs_scan_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  bcs_byte_if         byte_ch,
  bcs_result_if       result_ch,
  output int          mismatch_count_o,
  output int          pending_o
);
  import bcs_pkg::*;

  localparam logic [16:0] POSITION_CEIL = 17'h1_0001;
  localparam logic [16:0] OFFSET_CEIL   = 17'h0_ffff;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct {
    logic        found;
    logic [15:0] offset;
  } scan_result_t;

  mode_e        scan_mode;
  logic [63:0]  pattern;
  logic         after_first;
  logic         after_second;
  logic         answered;
  logic [16:0]  position;
  scan_result_t expected_q[$];
  int           mismatches = 0;

  function automatic logic [7:0] pattern_byte(input int idx);
    return pattern[(idx % 8) * 8 +: 8];
  endfunction

  function automatic logic member_of(input logic [7:0] x, input int start, input int count);
    for (int i = 0; i < count; i++) begin
      if (x == pattern_byte(start + i)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // bounds wrap modulo 256 when hi < lo
  function automatic logic within_bounds(input logic [7:0] x, input int lo_idx);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = pattern_byte(lo_idx);
    hi = pattern_byte(lo_idx + 1);
    return 8'(x - lo) <= 8'(hi - lo);
  endfunction

  function automatic void clear_history();
    after_first  = 1'b0;
    after_second = 1'b0;
    answered     = 1'b0;
    position     = '0;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void absorb_byte(input logic [7:0] x, input logic first, input logic last);
    logic         c1;
    logic         c2;
    logic         c3;
    logic         hit;
    int           span;
    int           k;
    logic [16:0]  here;
    logic [16:0]  off;
    scan_result_t res;
    c1   = 1'b0;
    c2   = 1'b0;
    c3   = 1'b0;
    span = 1;
    if (first) clear_history();
    case (scan_mode)
      MODE_PAIR: begin
        c1   = member_of(x, 0, 1);
        c2   = member_of(x, 1, 1);
        span = 2;
      end
      MODE_PAIR_SET2, MODE_PAIR_SET3, MODE_PAIR_SET4: begin
        k    = int'(scan_mode) - 7;
        c1   = member_of(x, 0, k);
        c2   = member_of(x, k, k);
        span = 2;
      end
      MODE_RANGE: begin
        c1 = within_bounds(x, 0);
      end
      MODE_RANGE_PAIR: begin
        c1   = within_bounds(x, 0);
        c2   = within_bounds(x, 2);
        span = 2;
      end
      MODE_TRIPLET: begin
        c1   = member_of(x, 0, 1);
        c2   = member_of(x, 1, 1);
        c3   = member_of(x, 2, 1);
        span = 3;
      end
      MODE_TRIPLET_SET: begin
        c1   = member_of(x, 0, 2);
        c2   = member_of(x, 2, 2);
        c3   = member_of(x, 4, 2);
        span = 3;
      end
      default: begin
        c1 = member_of(x, 0, int'(scan_mode) + 1);
      end
    endcase

    if (span == 1) hit = c1;
    else if (span == 2) hit = after_first && c2;
    else hit = after_second && c3;

    here         = position;
    after_second = after_first && c2;
    after_first  = c1;
    if (position < POSITION_CEIL) position++;

    if (!answered) begin
      if (hit) begin
        off = (here >= 17'(span - 1)) ? here - 17'(span - 1) : '0;
        if (off > OFFSET_CEIL) off = OFFSET_CEIL;
        res.found  = 1'b1;
        res.offset = off[15:0];
        expected_q.push_back(res);
        answered = 1'b1;
      end else if (last) begin
        res.found  = 1'b0;
        res.offset = '0;
        expected_q.push_back(res);
      end
    end
    if (last) clear_history();
  endfunction

  function automatic void check_result(input logic found, input logic [15:0] offset);
    scan_result_t want;
    if (expected_q.size() == 0) begin
      note_mismatch($sformatf("result with nothing outstanding: found=%0b offset=%0d",
                              found, offset));
    end else begin
      want = expected_q.pop_front();
      if (found !== want.found || offset !== want.offset) begin
        note_mismatch($sformatf("expected found=%0b offset=%0d, got found=%0b offset=%0d",
                                want.found, want.offset, found, offset));
      end
    end
  endfunction

  // result compared before the new byte is absorbed: its answer is registered and comes later
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode = MODE_ONE;
      pattern   = '0;
      clear_history();
      expected_q.delete();
      mismatch_count_o <= mismatches;
      pending_o        <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        check_result(result_ch.found, result_ch.match_offset);
      end
      if (byte_ch.valid && byte_ch.ready) begin
        absorb_byte(byte_ch.data_byte, byte_ch.first_of_buffer, byte_ch.last_of_buffer);
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MODE) scan_mode = mode_e'(cfg_data_i[3:0]);
        else pattern = cfg_data_i;
      end
      mismatch_count_o <= mismatches;
      pending_o        <= expected_q.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bcs_pkg::*;

  localparam int unsigned GAP_MAX      = 16;
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned RANDOM_BYTES = 1000;
  localparam int unsigned LONG_RUN     = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [63:0] cfg_data;
  int          mismatches;
  int          outstanding;
  bit          sender_idles   = 1'b1;
  bit          receiver_idles = 1'b1;
  logic [63:0] cur_pattern;
  int unsigned quiet_cycles;

  bcs_byte_if   byte_ch();
  bcs_result_if result_ch();

  byte_class_sequence_scanner_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_ch       (byte_ch),
    .out_ch      (result_ch)
  );

  bcs_scan_checker scan_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .byte_ch          (byte_ch),
    .result_ch        (result_ch),
    .mismatch_count_o (mismatches),
    .pending_o        (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned stall;
    result_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = receiver_idles ? $urandom_range(0, GAP_MAX) : 0;
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic first, input logic last);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, GAP_MAX) : 0;
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid           <= 1'b1;
    byte_ch.data_byte       <= value;
    byte_ch.first_of_buffer <= first;
    byte_ch.last_of_buffer  <= last;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  // hold off until every outstanding result has been taken
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(input mode_e m, input logic [63:0] p);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= 64'(m);
    @(posedge clk_i);
    cfg_index <= CFG_PATTERN;
    cfg_data  <= p;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    cur_pattern = p;
  endtask

  function automatic int class_count(input mode_e m);
    case (m)
      MODE_PAIR, MODE_PAIR_SET2, MODE_PAIR_SET3, MODE_PAIR_SET4, MODE_RANGE_PAIR: return 2;
      MODE_TRIPLET, MODE_TRIPLET_SET: return 3;
      default: return 1;
    endcase
  endfunction

  // a byte that belongs to class number step of mode m
  function automatic logic [7:0] class_member(input mode_e m, input int step);
    int         idx;
    int         k;
    logic [7:0] lo;
    logic [7:0] reach;
    case (m)
      MODE_PAIR, MODE_TRIPLET: idx = step;
      MODE_PAIR_SET2, MODE_PAIR_SET3, MODE_PAIR_SET4: begin
        k   = int'(m) - 7;
        idx = step * k + int'($urandom_range(0, k - 1));
      end
      MODE_TRIPLET_SET: idx = step * 2 + int'($urandom_range(0, 1));
      MODE_RANGE, MODE_RANGE_PAIR: begin
        lo    = cur_pattern[step * 16 +: 8];
        reach = cur_pattern[step * 16 + 8 +: 8] - lo;
        return lo + 8'($urandom_range(0, int'(reach)));
      end
      default: idx = int'($urandom_range(0, int'(m)));
    endcase
    return cur_pattern[idx * 8 +: 8];
  endfunction

  task automatic random_buffer(input mode_e m, input int unsigned len);
    logic       first;
    logic       last;
    logic [7:0] value;
    int         step;
    step = 0;
    for (int unsigned i = 0; i < len; i++) begin
      first = (i == 0);
      last  = (i == len - 1);
      if ($urandom_range(0, 19) == 0) first = ~first;
      if ($urandom_range(0, 19) == 0) last = ~last;
      if ($urandom_range(0, 3) != 0) begin
        value = class_member(m, step);
        step  = (step + 1) % class_count(m);
      end else begin
        value = 8'($urandom);
        step  = 0;
      end
      send_byte(value, first, last);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    mode_e       phase_mode;
    logic [63:0] phase_pattern;

    rst_ni                  <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_index               <= CFG_MODE;
    cfg_data                <= '0;
    byte_ch.valid           <= 1'b0;
    byte_ch.data_byte       <= '0;
    byte_ch.first_of_buffer <= 1'b0;
    byte_ch.last_of_buffer  <= 1'b0;
    cur_pattern             = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at their reset values
    send_byte(8'h00, 1'b1, 1'b1);
    settle();

    // no result after the answer; a last byte without first starts afresh
    load_config(MODE_ONE, 64'h00ff);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);
    send_byte(8'hff, 1'b0, 1'b1);
    settle();

    // wrapped range
    load_config(MODE_RANGE, 64'h10f0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h05, 1'b0, 1'b1);
    settle();

    // class change mid-buffer keeps the history
    load_config(MODE_PAIR, 64'h2211);
    send_byte(8'h11, 1'b1, 1'b0);
    settle();
    load_config(MODE_PAIR, 64'h3311);
    send_byte(8'h33, 1'b0, 1'b1);
    settle();

    for (int m = 0; m < 16; m++) begin
      load_config(mode_e'(m), 64'hffff_ffff_ffff_ff00);
      send_byte((m % 2 == 1) ? 8'hff : 8'h00, 1'b1, 1'b1);
      settle();
    end

    // triplet late in a buffer, bytes back to back
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    load_config(MODE_TRIPLET, 64'h005a_a5c3);
    send_byte(8'h00, 1'b1, 1'b0);
    for (int unsigned i = 1; i < LONG_RUN; i++) send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hc3, 1'b0, 1'b0);
    send_byte(8'ha5, 1'b0, 1'b0);
    send_byte(8'h5a, 1'b0, 1'b1);
    settle();

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 5))
        0:       phase_pattern = '0;
        1:       phase_pattern = '1;
        default: phase_pattern = {$urandom, $urandom};
      endcase
      phase_mode     = mode_e'($urandom_range(0, 15));
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      load_config(phase_mode, phase_pattern);
      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        random_buffer(phase_mode, len);
        sent += len;
      end
      settle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
